FILE: sv/sinpwm_pkg.sv
// ----------------------------------------------------------------------------
// Sine PWM duty package
// Shared types and fixed-point constants for the Q4.11 sine and duty pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sinpwm_pkg;

   // Q4.11 sample, 2048 is one
   typedef logic signed [15:0] sample_type;
   // Q11 duty gain
   typedef logic [14:0] gain_type;
   // PWM compare value
   typedef logic [4:0] duty_type;

   // Fold and mirror constants, Q4.11 radians, extended to 17 bits
   localparam logic signed [16:0] TWO_PI        = 17'sh03244;
   localparam logic signed [16:0] THREE_HALF_PI = 17'sh025B4;
   localparam logic signed [16:0] ONE_PI        = 17'sh01923;
   localparam logic signed [16:0] HALF_PI       = 17'sh00C91;
   // Angles at or beyond this need two steps of 2pi
   localparam logic signed [16:0] FOLD_TWICE    = THREE_HALF_PI + TWO_PI;

   // Q11 one and half, and the reset gain
   localparam logic signed [16:0] Q11_ONE    = 17'sh00800;
   localparam int                 Q11_HALF   = 'h0400;
   localparam gain_type           GAIN_RESET = 15'h7D00;
   localparam duty_type           DUTY_MAX   = 5'd31;

   // Upper bound on the magnitude of the polynomial output
   localparam sample_type SINE_ONE   = 16'sd2048;
   localparam sample_type SINE_BOUND = 16'sd2112;

endpackage

`default_nettype wire

FILE: sv/sinpwm_if.sv
// ----------------------------------------------------------------------------
// Sine PWM duty channels
// Valid/ready channels for angle requests and sine/duty responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface sinpwm_req_if;
   logic                   valid;
   logic                   ready;
   sinpwm_pkg::sample_type angle;

   modport source (output valid, output angle, input ready);
   modport sink   (input valid, input angle, output ready);
endinterface

interface sinpwm_rsp_if;
   logic                   valid;
   logic                   ready;
   sinpwm_pkg::sample_type sine_value;
   sinpwm_pkg::duty_type   duty;

   modport source (output valid, output sine_value, output duty, input ready);
   modport sink   (input valid, input sine_value, input duty, output ready);
endinterface

`default_nettype wire

FILE: sv/sinpwm_fold.sv
// ----------------------------------------------------------------------------
// Sine PWM angle reduction
// Two stages: fold by multiples of 2pi, then mirror into -pi/2..pi/2.
// ----------------------------------------------------------------------------
`default_nettype none

module sinpwm_fold (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  sinpwm_pkg::sample_type in_angle,
   output logic                   out_valid,
   input  logic                   out_ready,
   output sinpwm_pkg::sample_type out_x
);

   logic [1:0]             stage_ready;
   logic [1:0]             valid_ff;
   logic [1:0]             valid_in;
   sinpwm_pkg::sample_type fold_ff;
   sinpwm_pkg::sample_type fold_in;
   sinpwm_pkg::sample_type mirror_ff;
   sinpwm_pkg::sample_type mirror_in;
   logic signed [16:0]     ext;
   logic signed [16:0]     fext;
   logic signed [16:0]     m1;
   logic signed [16:0]     m2;

   // a stage loads when it is empty or its successor moves
   assign stage_ready[1] = !valid_ff[1] || out_ready;
   assign stage_ready[0] = !valid_ff[0] || stage_ready[1];
   assign in_ready       = stage_ready[0];

   always_comb begin
      valid_in[0] = stage_ready[0] ? in_valid    : valid_ff[0];
      valid_in[1] = stage_ready[1] ? valid_ff[0] : valid_ff[1];
   end

   // fold: at most two steps of 2pi in either direction
   always_comb begin
      ext = {in_angle[15], in_angle};
      priority if (ext >= sinpwm_pkg::FOLD_TWICE) begin
         fold_in = 16'(ext - (sinpwm_pkg::TWO_PI <<< 1));
      end else if (ext >= sinpwm_pkg::THREE_HALF_PI) begin
         fold_in = 16'(ext - sinpwm_pkg::TWO_PI);
      end else if (ext <= -sinpwm_pkg::FOLD_TWICE) begin
         fold_in = 16'(ext + (sinpwm_pkg::TWO_PI <<< 1));
      end else if (ext <= -sinpwm_pkg::THREE_HALF_PI) begin
         fold_in = 16'(ext + sinpwm_pkg::TWO_PI);
      end else begin
         fold_in = in_angle;
      end
   end

   // mirror about +pi/2, then about -pi/2
   always_comb begin
      fext = {fold_ff[15], fold_ff};
      if (fext >= sinpwm_pkg::HALF_PI && fext <= sinpwm_pkg::THREE_HALF_PI) begin
         m1 = sinpwm_pkg::ONE_PI - fext;
      end else begin
         m1 = fext;
      end
      if (m1 <= -sinpwm_pkg::HALF_PI && m1 >= -sinpwm_pkg::THREE_HALF_PI) begin
         m2 = -sinpwm_pkg::ONE_PI - m1;
      end else begin
         m2 = m1;
      end
      mirror_in = 16'(m2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 2'b00;
      end else begin
         valid_ff <= valid_in;
      end
      if (stage_ready[0]) begin
         fold_ff <= fold_in;
      end
      if (stage_ready[1]) begin
         mirror_ff <= mirror_in;
      end
   end

   assign out_valid = valid_ff[1];
   assign out_x     = mirror_ff;

endmodule

`default_nettype wire

FILE: sv/sinpwm_poly.sv
// ----------------------------------------------------------------------------
// Sine PWM polynomial
// Six stages: quotients x/2..x/5, four chained Q11 products, term sum.
// ----------------------------------------------------------------------------
`default_nettype none

module sinpwm_poly (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  sinpwm_pkg::sample_type in_x,
   output logic                   out_valid,
   input  logic                   out_ready,
   output sinpwm_pkg::sample_type out_sine
);

   localparam logic [16:0] RECIP3 = 17'd43691;  // ceil(2^17 / 3)
   localparam logic [15:0] RECIP5 = 16'd52429;  // ceil(2^18 / 5)

   // Q11 product, floor shift, wrapped to 16 bits
   function automatic sinpwm_pkg::sample_type q11_mul(input sinpwm_pkg::sample_type a,
                                                      input sinpwm_pkg::sample_type b);
      logic signed [31:0] p;
      p = 32'(a) * 32'(b);
      return p[26:11];
   endfunction

   // truncating division by two and four
   function automatic sinpwm_pkg::sample_type div2(input sinpwm_pkg::sample_type x);
      sinpwm_pkg::sample_type t;
      t = x + $signed({15'd0, x[15]});
      return t >>> 1;
   endfunction

   function automatic sinpwm_pkg::sample_type div4(input sinpwm_pkg::sample_type x);
      sinpwm_pkg::sample_type t;
      t = x + $signed({14'd0, x[15], x[15]});
      return t >>> 2;
   endfunction

   // truncating division by three and five through the magnitude
   function automatic sinpwm_pkg::sample_type div3(input sinpwm_pkg::sample_type x);
      logic [15:0] mag;
      logic [32:0] prod;
      logic [15:0] qm;
      mag  = x[15] ? (~x + 16'd1) : x;
      prod = 33'(mag) * 33'(RECIP3);
      qm   = prod[32:17];
      return x[15] ? (~qm + 16'd1) : qm;
   endfunction

   function automatic sinpwm_pkg::sample_type div5(input sinpwm_pkg::sample_type x);
      logic [15:0] mag;
      logic [31:0] prod;
      logic [15:0] qm;
      mag  = x[15] ? (~x + 16'd1) : x;
      prod = 32'(mag) * 32'(RECIP5);
      qm   = {2'b00, prod[31:18]};
      return x[15] ? (~qm + 16'd1) : qm;
   endfunction

   logic [5:0]             stage_ready;
   logic [5:0]             valid_ff;
   logic [5:0]             valid_in;

   sinpwm_pkg::sample_type p1_x_ff, p1_q2_ff, p1_q3_ff, p1_q4_ff, p1_q5_ff;
   sinpwm_pkg::sample_type p1_q2_in, p1_q3_in, p1_q4_in, p1_q5_in;
   sinpwm_pkg::sample_type p2_x_ff, p2_t2_ff, p2_q3_ff, p2_q4_ff, p2_q5_ff;
   sinpwm_pkg::sample_type p2_t2_in;
   sinpwm_pkg::sample_type p3_x_ff, p3_t3_ff, p3_q4_ff, p3_q5_ff;
   sinpwm_pkg::sample_type p3_t3_in;
   sinpwm_pkg::sample_type p4_x_ff, p4_t3_ff, p4_t4_ff, p4_q5_ff;
   sinpwm_pkg::sample_type p4_t4_in;
   sinpwm_pkg::sample_type p5_x_ff, p5_t3_ff, p5_t5_ff;
   sinpwm_pkg::sample_type p5_t5_in;
   sinpwm_pkg::sample_type p6_sum_ff;
   sinpwm_pkg::sample_type p6_sum_in;

   assign stage_ready[5] = !valid_ff[5] || out_ready;
   assign stage_ready[4] = !valid_ff[4] || stage_ready[5];
   assign stage_ready[3] = !valid_ff[3] || stage_ready[4];
   assign stage_ready[2] = !valid_ff[2] || stage_ready[3];
   assign stage_ready[1] = !valid_ff[1] || stage_ready[2];
   assign stage_ready[0] = !valid_ff[0] || stage_ready[1];
   assign in_ready       = stage_ready[0];

   always_comb begin
      valid_in[0] = stage_ready[0] ? in_valid    : valid_ff[0];
      valid_in[1] = stage_ready[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = stage_ready[2] ? valid_ff[1] : valid_ff[2];
      valid_in[3] = stage_ready[3] ? valid_ff[2] : valid_ff[3];
      valid_in[4] = stage_ready[4] ? valid_ff[3] : valid_ff[4];
      valid_in[5] = stage_ready[5] ? valid_ff[4] : valid_ff[5];
   end

   always_comb begin
      p1_q2_in  = div2(in_x);
      p1_q3_in  = div3(in_x);
      p1_q4_in  = div4(in_x);
      p1_q5_in  = div5(in_x);
      p2_t2_in  = q11_mul(p1_x_ff, p1_q2_ff);
      p3_t3_in  = q11_mul(p2_t2_ff, p2_q3_ff);
      p4_t4_in  = q11_mul(p3_t3_ff, p3_q4_ff);
      p5_t5_in  = q11_mul(p4_t4_ff, p4_q5_ff);
      p6_sum_in = p5_x_ff - p5_t3_ff + p5_t5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      if (stage_ready[0]) begin
         p1_x_ff  <= in_x;
         p1_q2_ff <= p1_q2_in;
         p1_q3_ff <= p1_q3_in;
         p1_q4_ff <= p1_q4_in;
         p1_q5_ff <= p1_q5_in;
      end
      if (stage_ready[1]) begin
         p2_x_ff  <= p1_x_ff;
         p2_t2_ff <= p2_t2_in;
         p2_q3_ff <= p1_q3_ff;
         p2_q4_ff <= p1_q4_ff;
         p2_q5_ff <= p1_q5_ff;
      end
      if (stage_ready[2]) begin
         p3_x_ff  <= p2_x_ff;
         p3_t3_ff <= p3_t3_in;
         p3_q4_ff <= p2_q4_ff;
         p3_q5_ff <= p2_q5_ff;
      end
      if (stage_ready[3]) begin
         p4_x_ff  <= p3_x_ff;
         p4_t3_ff <= p3_t3_ff;
         p4_t4_ff <= p4_t4_in;
         p4_q5_ff <= p3_q5_ff;
      end
      if (stage_ready[4]) begin
         p5_x_ff  <= p4_x_ff;
         p5_t3_ff <= p4_t3_ff;
         p5_t5_ff <= p5_t5_in;
      end
      if (stage_ready[5]) begin
         p6_sum_ff <= p6_sum_in;
      end
   end

   assign out_valid = valid_ff[5];
   assign out_sine  = p6_sum_ff;

endmodule

`default_nettype wire

FILE: sv/sinpwm_duty.sv
// ----------------------------------------------------------------------------
// Sine PWM duty extraction
// Two stages: scale (1 + sine) by the gain, then round, shift and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module sinpwm_duty (
   input  logic                   clock,
   input  logic                   reset,
   input  sinpwm_pkg::gain_type   gain,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  sinpwm_pkg::sample_type in_sine,
   output logic                   out_valid,
   input  logic                   out_ready,
   output sinpwm_pkg::sample_type out_sine,
   output sinpwm_pkg::duty_type   out_duty
);

   localparam int Q11_HALF_SHIFTED = sinpwm_pkg::Q11_HALF * 2048;
   localparam logic signed [33:0] ROUND = 34'(Q11_HALF_SHIFTED);

   logic [1:0]             stage_ready;
   logic [1:0]             valid_ff;
   logic [1:0]             valid_in;
   logic signed [16:0]     one_plus;
   logic signed [15:0]     gain_s;
   logic signed [32:0]     prod_ff;
   logic signed [32:0]     prod_in;
   sinpwm_pkg::sample_type d1_sine_ff;
   sinpwm_pkg::sample_type d2_sine_ff;
   logic signed [33:0]     rnd;
   sinpwm_pkg::duty_type   duty_ff;
   sinpwm_pkg::duty_type   duty_in;

   assign stage_ready[1] = !valid_ff[1] || out_ready;
   assign stage_ready[0] = !valid_ff[0] || stage_ready[1];
   assign in_ready       = stage_ready[0];

   always_comb begin
      valid_in[0] = stage_ready[0] ? in_valid    : valid_ff[0];
      valid_in[1] = stage_ready[1] ? valid_ff[0] : valid_ff[1];
   end

   always_comb begin
      one_plus = {in_sine[15], in_sine} + sinpwm_pkg::Q11_ONE;
      gain_s   = $signed({1'b0, gain});
      prod_in  = 33'(one_plus) * 33'(gain_s);
   end

   // two floor shifts by 11 with the half added between them fold into one
   always_comb begin
      rnd = {prod_ff[32], prod_ff} + ROUND;
      priority if (rnd[33]) begin
         duty_in = '0;
      end else if (rnd[32:22] > 11'(sinpwm_pkg::DUTY_MAX)) begin
         duty_in = sinpwm_pkg::DUTY_MAX;
      end else begin
         duty_in = rnd[26:22];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 2'b00;
      end else begin
         valid_ff <= valid_in;
      end
      if (stage_ready[0]) begin
         prod_ff    <= prod_in;
         d1_sine_ff <= in_sine;
      end
      if (stage_ready[1]) begin
         duty_ff    <= duty_in;
         d2_sine_ff <= d1_sine_ff;
      end
   end

   assign out_valid = valid_ff[1];
   assign out_sine  = d2_sine_ff;
   assign out_duty  = duty_ff;

endmodule

`default_nettype wire

FILE: sv/fixed_point_sine_pwm_duty_unit.sv
// ----------------------------------------------------------------------------
// Fixed-point sine PWM duty unit
// Q4.11 angle in, fifth-order sine and a saturated 5-bit PWM duty out.
// ----------------------------------------------------------------------------
//
//   Port          Dir   Width  Contents
//   req_port      in    16     angle, signed Q4.11 radians (valid/ready)
//   rsp_port      out   16+5   sine_value signed Q4.11, duty 0..31 (valid/ready)
//   csr_wr_*      in    15     duty_gain, Q11, written when csr_wr_en is high
//
// Throughput is one item per clock while rsp_port is ready; the chain has
// ten register stages: fold, mirror, quotients, four Q11 products, sum,
// gain product, and duty rounding.
// Reset clears every stage's valid bit and loads the gain with 32000.
// Each stage loads when it is empty or the next stage moves, so back-pressure
// passes combinationally back through full stages and empty slots fill while the output waits.
//
`default_nettype none

module fixed_point_sine_pwm_duty_unit (
   input  logic                       clock,
   input  logic                       reset,
   sinpwm_req_if.sink                 req_port,
   sinpwm_rsp_if.source               rsp_port,
   input  logic                       csr_wr_en,
   input  sinpwm_pkg::gain_type       csr_wr_data
);

   // duty gain register
   sinpwm_pkg::gain_type   gain_ff;
   sinpwm_pkg::gain_type   gain_in;

   // fold -> poly
   logic                   fold_valid;
   logic                   fold_ready;
   sinpwm_pkg::sample_type fold_x;

   // poly -> duty
   logic                   poly_valid;
   logic                   poly_ready;
   sinpwm_pkg::sample_type poly_sine;

   // take a new gain on a write, hold it otherwise
   assign gain_in = csr_wr_en ? csr_wr_data : gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= sinpwm_pkg::GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
   end

   // reduce the angle into -pi/2..pi/2
   sinpwm_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_port.valid),
      .in_ready  (req_port.ready),
      .in_angle  (req_port.angle),
      .out_valid (fold_valid),
      .out_ready (fold_ready),
      .out_x     (fold_x)
   );

   // evaluate x - x^3/6 + x^5/120
   sinpwm_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fold_valid),
      .in_ready  (fold_ready),
      .in_x      (fold_x),
      .out_valid (poly_valid),
      .out_ready (poly_ready),
      .out_sine  (poly_sine)
   );

   // scale, round and clamp into the PWM compare value
   sinpwm_duty u_duty (
      .clock     (clock),
      .reset     (reset),
      .gain      (gain_ff),
      .in_valid  (poly_valid),
      .in_ready  (poly_ready),
      .in_sine   (poly_sine),
      .out_valid (rsp_port.valid),
      .out_ready (rsp_port.ready),
      .out_sine  (rsp_port.sine_value),
      .out_duty  (rsp_port.duty)
   );

`ifndef SYNTH
   // nothing leaves the pipeline right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_port.valid)
      else $error("response valid after reset");

   // an empty output stage frees the whole chain
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_port.valid |-> req_port.ready)
      else $error("request stalled with empty output");

   // folded polynomial never leaves the unit range by much
   a_sine_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid |-> (rsp_port.sine_value <= sinpwm_pkg::SINE_BOUND) &&
                         (rsp_port.sine_value >= -sinpwm_pkg::SINE_BOUND))
      else $error("sine value out of range");

   // one plus sine below zero saturates the duty at zero
   a_duty_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && (rsp_port.sine_value < -sinpwm_pkg::SINE_ONE)
      |-> rsp_port.duty == '0)
      else $error("duty not clamped at zero");

   // a register write lands in the gain
   a_gain_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> gain_ff == $past(csr_wr_data))
      else $error("duty gain write lost");
`endif

endmodule

`default_nettype wire
